// ----- design/mic_pkg.sv -----
package mic_pkg;

    localparam int COEF_FRAC_BITS_DEF = 12;
    localparam int HEADING_BITS_DEF   = 16;

    localparam int CORDIC_STEPS = 28;
    localparam int CORDIC_SHIFT = 12;
    localparam int CORDIC_W     = 34;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    localparam int CAL_W    = 18;
    localparam int RAW_W    = 16;
    localparam int CFG_W    = 48;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BIAS_X = 3'd0,
        REG_BIAS_Y = 3'd1,
        REG_BIAS_Z = 3'd2,
        REG_ROW_X  = 3'd3,
        REG_ROW_Y  = 3'd4,
        REG_ROW_Z  = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic signed [15:0] bias_x;
        logic signed [15:0] bias_y;
        logic signed [15:0] bias_z;
        logic [47:0]        row_x;
        logic [47:0]        row_y;
        logic [47:0]        row_z;
    } cfg_t;

    typedef struct packed {
        logic signed [15:0] raw_x;
        logic signed [15:0] raw_y;
        logic signed [15:0] raw_z;
        logic signed [16:0] dif_x;
        logic signed [16:0] dif_y;
        logic signed [16:0] dif_z;
    } item_t;

    // arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] a;
        case (i)
            0:  a = 32'd536870912;
            1:  a = 32'd316933406;
            2:  a = 32'd167458907;
            3:  a = 32'd85004756;
            4:  a = 32'd42667331;
            5:  a = 32'd21354465;
            6:  a = 32'd10679838;
            7:  a = 32'd5340245;
            8:  a = 32'd2670163;
            9:  a = 32'd1335087;
            10: a = 32'd667544;
            11: a = 32'd333772;
            12: a = 32'd166886;
            13: a = 32'd83443;
            14: a = 32'd41722;
            15: a = 32'd20861;
            16: a = 32'd10430;
            17: a = 32'd5215;
            18: a = 32'd2608;
            19: a = 32'd1304;
            20: a = 32'd652;
            21: a = 32'd326;
            22: a = 32'd163;
            23: a = 32'd81;
            24: a = 32'd41;
            25: a = 32'd20;
            26: a = 32'd10;
            27: a = 32'd5;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

endpackage

// ----- design/magnetometer_iron_correction.sv -----
// channel  dir  handshake            payload
// s_       in   s_valid / s_ready    s_raw_x, s_raw_y, s_raw_z
// m_       out  m_valid / m_ready    m_cal_x/y/z, m_heading, m_raw/cal_magnitude
// cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One beat per cycle in and out unless the back stalls; a beat passes the
// product and row-sum stages, fold, 28-step heading CORDIC and rounding stage.
// A 4-entry queue behind the input absorbs up to 4 beats while the back stalls.
// The back pipeline stalls as a whole when m_valid is held without m_ready.
// Synchronous active-low reset clears control and loads identity/zero config.
module magnetometer_iron_correction #(
    parameter int COEF_FRAC_BITS = mic_pkg::COEF_FRAC_BITS_DEF,
    parameter int HEADING_BITS   = mic_pkg::HEADING_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_raw_x,
    input  logic signed [15:0] s_raw_y,
    input  logic signed [15:0] s_raw_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [17:0] m_cal_x,
    output logic signed [17:0] m_cal_y,
    output logic signed [17:0] m_cal_z,
    output logic [15:0]        m_heading,
    output logic [15:0]        m_raw_magnitude,
    output logic [17:0]        m_cal_magnitude,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [47:0]        cfg_data
);

    localparam logic [47:0] ONE = 48'd1;

    mic_pkg::cfg_t   cfg_reg;
    logic            q_valid;
    logic            q_pop;
    mic_pkg::item_t  q_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bias_x <= '0;
            cfg_reg.bias_y <= '0;
            cfg_reg.bias_z <= '0;
            cfg_reg.row_x  <= ONE << COEF_FRAC_BITS;
            cfg_reg.row_y  <= ONE << (COEF_FRAC_BITS + 16);
            cfg_reg.row_z  <= ONE << (COEF_FRAC_BITS + 32);
        end else if (cfg_valid) begin
            case (cfg_index)
                mic_pkg::REG_BIAS_X: cfg_reg.bias_x <= cfg_data[15:0];
                mic_pkg::REG_BIAS_Y: cfg_reg.bias_y <= cfg_data[15:0];
                mic_pkg::REG_BIAS_Z: cfg_reg.bias_z <= cfg_data[15:0];
                mic_pkg::REG_ROW_X:  cfg_reg.row_x  <= cfg_data;
                mic_pkg::REG_ROW_Y:  cfg_reg.row_y  <= cfg_data;
                mic_pkg::REG_ROW_Z:  cfg_reg.row_z  <= cfg_data;
                default: ;
            endcase
        end
    end

    mic_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_raw_x (s_raw_x),
        .s_raw_y (s_raw_y),
        .s_raw_z (s_raw_z),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    mic_back #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .HEADING_BITS   (HEADING_BITS)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .q_valid         (q_valid),
        .q_item          (q_item),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_cal_x         (m_cal_x),
        .m_cal_y         (m_cal_y),
        .m_cal_z         (m_cal_z),
        .m_heading       (m_heading),
        .m_raw_magnitude (m_raw_magnitude),
        .m_cal_magnitude (m_cal_magnitude)
    );

endmodule

// ----- design/mic_front.sv -----
module mic_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [15:0]  s_raw_x,
    input  logic signed [15:0]  s_raw_y,
    input  logic signed [15:0]  s_raw_z,
    input  mic_pkg::cfg_t       cfg,
    output logic                q_valid,
    output mic_pkg::item_t      q_item,
    input  logic                q_pop
);

    mic_pkg::item_t                  mem_reg [mic_pkg::QUEUE_DEPTH];
    logic [mic_pkg::QUEUE_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [mic_pkg::QUEUE_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [mic_pkg::QUEUE_AW:0]      count_reg, count_next;
    logic                            push;
    mic_pkg::item_t                  item;

    assign s_ready = (count_reg != (mic_pkg::QUEUE_AW+1)'(mic_pkg::QUEUE_DEPTH));
    assign push    = s_valid & s_ready;
    assign q_valid = (count_reg != '0);
    assign q_item  = mem_reg[rd_ptr_reg];

    always_comb begin
        item.raw_x = s_raw_x;
        item.raw_y = s_raw_y;
        item.raw_z = s_raw_z;
        item.dif_x = 17'(s_raw_x) - 17'(cfg.bias_x);
        item.dif_y = 17'(s_raw_y) - 17'(cfg.bias_y);
        item.dif_z = 17'(s_raw_z) - 17'(cfg.bias_z);
    end

    always_comb begin
        wr_ptr_next = push  ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && q_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

// ----- design/mic_isqrt.sv -----
module mic_isqrt #(
    parameter int W = 32
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [W-1:0]     din,
    output logic [W/2-1:0]   dout
);

    localparam int N = W / 2;

    logic [W-1:0]   v_reg    [N];
    logic [N+1:0]   rem_reg  [N];
    logic [N-1:0]   root_reg [N];

    // one root bit per stage, restoring form
    for (genvar k = 0; k < N; k++) begin : g_stage
        logic [W-1:0] pv;
        logic [N+1:0] prem;
        logic [N-1:0] proot;
        logic [N+1:0] rem_sh;
        logic [N+1:0] trial;
        logic         ge;

        if (k == 0) begin : g_first
            assign pv    = din;
            assign prem  = '0;
            assign proot = '0;
        end else begin : g_rest
            assign pv    = v_reg[k-1];
            assign prem  = rem_reg[k-1];
            assign proot = root_reg[k-1];
        end

        assign rem_sh = {prem[N-1:0], pv[W-1 -: 2]};
        assign trial  = {proot, 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge aclk) begin
            if (en) begin
                v_reg[k]    <= pv << 2;
                rem_reg[k]  <= ge ? rem_sh - trial : rem_sh;
                root_reg[k] <= {proot[N-2:0], ge};
            end
        end
    end

    assign dout = root_reg[N-1];

endmodule

// ----- design/mic_cordic.sv -----
module mic_cordic #(
    parameter int HEADING_BITS = mic_pkg::HEADING_BITS_DEF
) (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [17:0] cal_x,
    input  logic signed [17:0] cal_y,
    output logic [15:0]        heading
);

    localparam int CW = mic_pkg::CORDIC_W;
    localparam int NS = mic_pkg::CORDIC_STEPS;
    localparam logic [31:0] HALF_LSB = 32'd1 << (31 - HEADING_BITS);

    logic signed [CW-1:0] x_reg [NS+1];
    logic signed [CW-1:0] y_reg [NS+1];
    logic [31:0]          z_reg [NS+1];
    logic                 zf_reg [NS+1];
    logic [15:0]          hd_reg;

    logic signed [CW-1:0] px, py;
    logic [31:0]          zr, hfull;

    assign px = CW'(cal_y) <<< mic_pkg::CORDIC_SHIFT;
    assign py = -(CW'(cal_x) <<< mic_pkg::CORDIC_SHIFT);

    // fold the left half-plane onto the right
    always_ff @(posedge aclk) begin
        if (en) begin
            zf_reg[0] <= (cal_x == '0) && (cal_y == '0);
            if (px[CW-1]) begin
                x_reg[0] <= -px;
                y_reg[0] <= -py;
                z_reg[0] <= 32'h8000_0000;
            end else begin
                x_reg[0] <= px;
                y_reg[0] <= py;
                z_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < NS; i++) begin : g_step
        logic signed [CW-1:0] xs, ys;
        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;

        always_ff @(posedge aclk) begin
            if (en) begin
                zf_reg[i+1] <= zf_reg[i];
                if (!y_reg[i][CW-1]) begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    z_reg[i+1] <= z_reg[i] + mic_pkg::atan_turn(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    z_reg[i+1] <= z_reg[i] - mic_pkg::atan_turn(i);
                end
            end
        end
    end

    assign zr    = z_reg[NS] + HALF_LSB;
    assign hfull = zr >> (32 - HEADING_BITS);

    always_ff @(posedge aclk) begin
        if (en) begin
            hd_reg <= zf_reg[NS] ? '0 : hfull[15:0];
        end
    end

    assign heading = hd_reg;

endmodule

// ----- design/mic_back.sv -----
module mic_back #(
    parameter int COEF_FRAC_BITS = mic_pkg::COEF_FRAC_BITS_DEF,
    parameter int HEADING_BITS   = mic_pkg::HEADING_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  mic_pkg::cfg_t      cfg,
    input  logic               q_valid,
    input  mic_pkg::item_t     q_item,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [17:0] m_cal_x,
    output logic signed [17:0] m_cal_y,
    output logic signed [17:0] m_cal_z,
    output logic [15:0]        m_heading,
    output logic [15:0]        m_raw_magnitude,
    output logic [17:0]        m_cal_magnitude
);

    localparam int HD_LAT   = mic_pkg::CORDIC_STEPS + 2;
    localparam int RAW_LAT  = 16;
    localparam int CAL_LAT  = 2 + 18;
    localparam int RAW_PAD  = HD_LAT - RAW_LAT;
    localparam int CAL_PAD  = HD_LAT - CAL_LAT;
    localparam int VLD_LEN  = 2 + HD_LAT;
    localparam logic signed [34:0] RND = 35'sd1 <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [34:0] SAT_HI = 35'sd131071;
    localparam logic signed [34:0] SAT_LO = -35'sd131072;

    logic [VLD_LEN-1:0]  vld_reg;
    logic                en;

    logic [47:0]         rows [3];
    logic signed [16:0]  dif  [3];
    logic signed [15:0]  raw  [3];

    logic signed [32:0]  prod_reg [9];
    logic [30:0]         rsq_reg  [3];
    logic signed [17:0]  cal_reg  [3];
    logic [31:0]         rsum_reg;
    logic [34:0]         csq_reg  [3];
    logic [35:0]         csum_reg;

    logic signed [34:0]  rsum_c [3];
    logic signed [34:0]  rsh_c  [3];
    logic signed [17:0]  cal_c  [3];

    logic signed [17:0]  calx_dly_reg [HD_LAT];
    logic signed [17:0]  caly_dly_reg [HD_LAT];
    logic signed [17:0]  calz_dly_reg [HD_LAT];
    logic [15:0]         rmag_dly_reg [RAW_PAD];
    logic [17:0]         cmag_dly_reg [CAL_PAD];

    logic [15:0]         rmag;
    logic [17:0]         cmag;
    logic [18:0]         abs_cx;

    // whole pipeline moves together; the last stage is the output register
    assign en      = !vld_reg[VLD_LEN-1] || m_ready;
    assign q_pop   = en && q_valid;
    assign m_valid = vld_reg[VLD_LEN-1];

    assign rows[0] = cfg.row_x;
    assign rows[1] = cfg.row_y;
    assign rows[2] = cfg.row_z;
    assign dif[0]  = q_item.dif_x;
    assign dif[1]  = q_item.dif_y;
    assign dif[2]  = q_item.dif_z;
    assign raw[0]  = q_item.raw_x;
    assign raw[1]  = q_item.raw_y;
    assign raw[2]  = q_item.raw_z;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[VLD_LEN-2:0], q_valid};
        end
    end

    // stage 1: coefficient products and raw squares
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    prod_reg[3*r+c] <= $signed(rows[r][16*c +: 16]) * dif[c];
                end
                rsq_reg[r] <= 31'(raw[r] * raw[r]);
            end
        end
    end

    // stage 2: row sums, round half up, saturate
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            rsum_c[r] = 35'(prod_reg[3*r]) + 35'(prod_reg[3*r+1])
                      + 35'(prod_reg[3*r+2]) + RND;
            rsh_c[r]  = rsum_c[r] >>> COEF_FRAC_BITS;
            if (rsh_c[r] > SAT_HI) begin
                cal_c[r] = 18'sd131071;
            end else if (rsh_c[r] < SAT_LO) begin
                cal_c[r] = -18'sd131072;
            end else begin
                cal_c[r] = rsh_c[r][17:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                cal_reg[r] <= cal_c[r];
                csq_reg[r] <= 35'(cal_reg[r] * cal_reg[r]);
            end
            rsum_reg <= 32'(rsq_reg[0]) + 32'(rsq_reg[1]) + 32'(rsq_reg[2]);
            csum_reg <= 36'(csq_reg[0]) + 36'(csq_reg[1]) + 36'(csq_reg[2]);
        end
    end

    mic_cordic #(
        .HEADING_BITS (HEADING_BITS)
    ) u_cordic (
        .aclk    (aclk),
        .en      (en),
        .cal_x   (cal_reg[0]),
        .cal_y   (cal_reg[1]),
        .heading (m_heading)
    );

    mic_isqrt #(
        .W (32)
    ) u_raw_sqrt (
        .aclk (aclk),
        .en   (en),
        .din  (rsum_reg),
        .dout (rmag)
    );

    mic_isqrt #(
        .W (36)
    ) u_cal_sqrt (
        .aclk (aclk),
        .en   (en),
        .din  (csum_reg),
        .dout (cmag)
    );

    // line everything up with the heading
    always_ff @(posedge aclk) begin
        if (en) begin
            calx_dly_reg[0] <= cal_reg[0];
            caly_dly_reg[0] <= cal_reg[1];
            calz_dly_reg[0] <= cal_reg[2];
            for (int i = 1; i < HD_LAT; i++) begin
                calx_dly_reg[i] <= calx_dly_reg[i-1];
                caly_dly_reg[i] <= caly_dly_reg[i-1];
                calz_dly_reg[i] <= calz_dly_reg[i-1];
            end
            rmag_dly_reg[0] <= rmag;
            for (int i = 1; i < RAW_PAD; i++) begin
                rmag_dly_reg[i] <= rmag_dly_reg[i-1];
            end
            cmag_dly_reg[0] <= cmag;
            for (int i = 1; i < CAL_PAD; i++) begin
                cmag_dly_reg[i] <= cmag_dly_reg[i-1];
            end
        end
    end

    assign m_cal_x         = calx_dly_reg[HD_LAT-1];
    assign m_cal_y         = caly_dly_reg[HD_LAT-1];
    assign m_cal_z         = calz_dly_reg[HD_LAT-1];
    assign m_raw_magnitude = rmag_dly_reg[RAW_PAD-1];
    assign m_cal_magnitude = cmag_dly_reg[CAL_PAD-1];

    assign abs_cx = m_cal_x[17] ? (19'd0 - {m_cal_x[17], m_cal_x}) : {1'b0, m_cal_x};

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_heading) && $stable(m_cal_x))
        else $error("result changed while stalled");

    a_zero_heading: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_cal_x == '0) && (m_cal_y == '0) |-> (m_heading == '0))
        else $error("heading of zero vector not zero");

    a_mag_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ({1'b0, m_cal_magnitude} >= abs_cx))
        else $error("calibrated magnitude below x component");

    a_pop_only_when_moving: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> vld_reg[0])
        else $error("popped beat lost at pipeline entry");

endmodule
